FILE: hdl/smx_pkg.sv
package smx_pkg;

   // default sizes
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int MEM_WORDS_DEF   = 128;

   // fixed field widths
   localparam int IP_W    = 16;
   localparam int WORD_W  = 32;
   localparam int OPC_W   = 4;
   localparam int OPER_W  = 2;
   localparam int FAULT_W = 3;
   localparam int COUNT_W = 11;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;

   localparam logic [IP_W-1:0]   PLEN_RESET    = 16'hFFFF;
   localparam logic [CSR_AW-1:0] CSR_PLEN_ADDR = 2'd0;

   typedef enum logic [OPER_W-1:0] {
      OP_EXEC    = 2'd0,
      OP_HOST_WR = 2'd1,
      OP_HOST_RD = 2'd2,
      OP_IGNORE  = 2'd3
   } oper_type;

   typedef enum logic [OPC_W-1:0] {
      OPC_LOAD  = 4'd0,
      OPC_STORE = 4'd1,
      OPC_ADD   = 4'd2,
      OPC_SUB   = 4'd3,
      OPC_MUL   = 4'd4,
      OPC_DIV   = 4'd5,
      OPC_JMP   = 4'd6,
      OPC_JZ    = 4'd7,
      OPC_HALT  = 4'd8
   } opc_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE   = 3'd0,
      FAULT_UNDER  = 3'd1,
      FAULT_OVER   = 3'd2,
      FAULT_ADDR   = 3'd3,
      FAULT_OPCODE = 3'd4
   } fault_type;

   // one input item as held in the execute stage
   typedef struct packed {
      oper_type           op;
      logic [OPC_W-1:0]   opc;
      logic [IP_W-1:0]    opnd;
      logic [WORD_W-1:0]  wdata;
   } item_type;

   // execute stage outcome (stack pointer travels separately, its width is a parameter)
   typedef struct packed {
      logic [IP_W-1:0]    ip;
      logic               halt;
      logic [WORD_W-1:0]  top;
      fault_type          fault;
      logic [WORD_W-1:0]  read_data;
      logic               dm_we;
      logic [WORD_W-1:0]  dm_wdata;
      logic               st_we;
   } upd_type;

endpackage

FILE: hdl/smx_ram.sv
module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/smx_exec.sv
module smx_exec #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
   parameter int MEM_WORDS   = smx_pkg::MEM_WORDS_DEF,
   localparam int SP_W       = $clog2(STACK_DEPTH + 1)
) (
   input  smx_pkg::item_type                item,
   input  logic [SP_W-1:0]                  sp,
   input  logic [smx_pkg::IP_W-1:0]         ip,
   input  logic                             halt,
   input  logic [smx_pkg::WORD_W-1:0]       top,
   input  logic [smx_pkg::IP_W-1:0]         plen,
   input  logic [smx_pkg::WORD_W-1:0]       dm_rdata,
   input  logic [smx_pkg::WORD_W-1:0]       st_rdata,
   output smx_pkg::upd_type                 upd,
   output logic [SP_W-1:0]                  sp_nx
);

   logic                        halted_now;
   logic                        addr_bad;
   logic                        sp_empty;
   logic                        sp_lt2;
   logic                        sp_full;
   logic [smx_pkg::WORD_W-1:0]  prod;
   logic [smx_pkg::IP_W-1:0]    ip_inc;

   // stack top is cached in a register; st_rdata is the entry just below it
   assign prod     = st_rdata * top;
   assign ip_inc   = ip + smx_pkg::IP_W'(1);
   assign addr_bad = {1'b0, item.opnd} >= (smx_pkg::IP_W + 1)'(MEM_WORDS);
   assign sp_empty = (sp == '0);
   assign sp_lt2   = (sp < SP_W'(2));
   assign sp_full  = (sp >= SP_W'(STACK_DEPTH));

   always_comb begin
      halted_now    = halt || (ip >= plen);
      sp_nx         = sp;
      upd.ip        = ip;
      upd.halt      = halt;
      upd.top       = top;
      upd.fault     = smx_pkg::FAULT_NONE;
      upd.read_data = '0;
      upd.dm_we     = 1'b0;
      upd.dm_wdata  = item.wdata;
      upd.st_we     = 1'b0;

      unique case (item.op)
         smx_pkg::OP_EXEC: begin
            if (!halted_now) begin
               upd.ip = ip_inc;
               unique case (smx_pkg::opc_type'(item.opc))
                  smx_pkg::OPC_LOAD: begin
                     if (addr_bad) begin
                        upd.fault = smx_pkg::FAULT_ADDR;
                     end else if (sp_full) begin
                        upd.fault = smx_pkg::FAULT_OVER;
                     end else begin
                        upd.st_we = !sp_empty;   // spill old top below the new one
                        upd.top   = dm_rdata;
                        sp_nx     = sp + SP_W'(1);
                     end
                  end
                  smx_pkg::OPC_STORE: begin
                     if (addr_bad) begin
                        upd.fault = smx_pkg::FAULT_ADDR;
                     end else if (sp_empty) begin
                        upd.fault = smx_pkg::FAULT_UNDER;
                     end else begin
                        upd.dm_we    = 1'b1;
                        upd.dm_wdata = top;
                        upd.top      = st_rdata;
                        sp_nx        = sp - SP_W'(1);
                     end
                  end
                  smx_pkg::OPC_ADD, smx_pkg::OPC_SUB, smx_pkg::OPC_MUL: begin
                     if (sp_lt2) begin
                        upd.fault = smx_pkg::FAULT_UNDER;
                     end else begin
                        case (smx_pkg::opc_type'(item.opc))
                           smx_pkg::OPC_ADD: upd.top = st_rdata + top;
                           smx_pkg::OPC_SUB: upd.top = st_rdata - top;
                           default:          upd.top = prod;
                        endcase
                        sp_nx = sp - SP_W'(1);
                     end
                  end
                  smx_pkg::OPC_DIV: begin
                  end
                  smx_pkg::OPC_JMP: begin
                     upd.ip = item.opnd;
                  end
                  smx_pkg::OPC_JZ: begin
                     if (sp_empty) begin
                        upd.fault = smx_pkg::FAULT_UNDER;
                     end else begin
                        if (top == '0) begin
                           upd.ip = item.opnd;
                        end
                        upd.top = st_rdata;
                        sp_nx   = sp - SP_W'(1);
                     end
                  end
                  smx_pkg::OPC_HALT: begin
                     upd.halt = 1'b1;
                  end
                  default: begin
                     upd.fault = smx_pkg::FAULT_OPCODE;
                  end
               endcase
               if (upd.fault != smx_pkg::FAULT_NONE) begin
                  upd.halt = 1'b1;
               end
            end
         end
         smx_pkg::OP_HOST_WR: begin
            if (addr_bad) begin
               upd.fault = smx_pkg::FAULT_ADDR;
            end else begin
               upd.dm_we = 1'b1;
            end
         end
         smx_pkg::OP_HOST_RD: begin
            if (addr_bad) begin
               upd.fault = smx_pkg::FAULT_ADDR;
            end else begin
               upd.read_data = dm_rdata;
            end
         end
         default: begin
         end
      endcase

      if (upd.ip >= plen) begin
         upd.halt = 1'b1;
      end
   end

endmodule

FILE: hdl/stack_machine_executor.sv
// Stack machine executor. Each req item carries one instruction (fetched by the host
// from program[ip]) or a host write/read of a data-memory word; each item yields exactly
// one rsp item with the instruction pointer, halt status, host read data, top of stack,
// stack depth and fault code after that item. In the accept cycle the data memory (at
// the operand) and the stack memory (at the entry below the cached top) are read; both
// are synchronous RAMs with registered read data. Once the item sits in the execute
// stage, the instruction executes and state, memory writes and the rsp register are
// committed, unless the rsp register still holds a stalled result. req_stall is high
// while an item sits in the execute stage, so a new item is taken only after the
// previous one has committed; this interlock keeps the next item's memory reads
// behind the previous item's writes. The rsp register decouples the two channels: a
// new item is accepted while a finished result waits, and the execute stage only holds
// when that register is still occupied and stalled.
// The top of stack lives in a register, so the stack RAM holds only the entries below it.
// Data memory and stack contents are undefined after reset (no clearing pass); reading
// a data word that was never written returns an arbitrary value. program_length sits
// at byte address 0 of the APB port (reset 0xFFFF); it must be written only while idle.
module stack_machine_executor #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
   parameter int MEM_WORDS   = smx_pkg::MEM_WORDS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [smx_pkg::OPER_W-1:0]           req_operation,
   input  logic [smx_pkg::OPC_W-1:0]            req_opcode,
   input  logic [smx_pkg::IP_W-1:0]             req_operand,
   input  logic signed [smx_pkg::WORD_W-1:0]    req_write_data,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [smx_pkg::IP_W-1:0]             rsp_next_ip,
   output logic                                 rsp_halted,
   output logic signed [smx_pkg::WORD_W-1:0]    rsp_read_data,
   output logic signed [smx_pkg::WORD_W-1:0]    rsp_top_value,
   output logic [smx_pkg::COUNT_W-1:0]          rsp_stack_count,
   output logic [smx_pkg::FAULT_W-1:0]          rsp_fault,

   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [smx_pkg::CSR_AW-1:0]           paddr,
   input  logic [smx_pkg::CSR_DW-1:0]           pwdata,
   output logic [smx_pkg::CSR_DW-1:0]           prdata,
   output logic                                 pready
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);   // holds 0..STACK_DEPTH
   localparam int SI_W = $clog2(STACK_DEPTH);       // stack RAM index
   localparam int MI_W = $clog2(MEM_WORDS);         // data RAM index

   // ---------------------------------------------------------------- control
   logic                           req_accept;
   logic                           commit;
   logic                           b_valid_ff, b_valid_in;
   smx_pkg::item_type              b_item_ff, b_item_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------- machine state
   logic [SP_W-1:0]                sp_ff, sp_in;
   logic [smx_pkg::IP_W-1:0]       ip_ff, ip_in;
   logic                           halt_ff, halt_in;
   logic [smx_pkg::WORD_W-1:0]     top_ff, top_in;
   logic [smx_pkg::IP_W-1:0]       plen_ff, plen_in;

   // ---------------------------------------------------------------- rsp register
   logic [smx_pkg::IP_W-1:0]       out_ip_ff, out_ip_in;
   logic                           out_halt_ff, out_halt_in;
   logic [smx_pkg::WORD_W-1:0]     out_rdata_ff, out_rdata_in;
   logic [smx_pkg::WORD_W-1:0]     out_top_ff, out_top_in;
   logic [smx_pkg::COUNT_W-1:0]    out_count_ff, out_count_in;
   logic [smx_pkg::FAULT_W-1:0]    out_fault_ff, out_fault_in;

   // ---------------------------------------------------------------- datapath
   logic [SP_W-1:0]                sp_m1, sp_m2;
   logic [smx_pkg::WORD_W-1:0]     dm_rdata, st_rdata;
   smx_pkg::upd_type               upd;
   logic [SP_W-1:0]                sp_nx;
   logic                           csr_wr;

   // Handshakes. The execute stage holds one item; the interlock keeps the
   // next item's RAM reads after the current item's RAM writes.
   assign req_stall  = b_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign commit     = b_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign b_valid_in   = req_accept ? 1'b1 : (commit ? 1'b0 : b_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_comb begin
      b_item_in = b_item_ff;
      if (req_accept) begin
         b_item_in.op    = smx_pkg::oper_type'(req_operation);
         b_item_in.opc   = req_opcode;
         b_item_in.opnd  = req_operand;
         b_item_in.wdata = req_write_data;
      end
   end

   // Read addresses are issued in the accept cycle. The stack RAM is read at
   // sp-2, the entry under the cached top (second operand or new top after a pop).
   assign sp_m1 = sp_ff - SP_W'(1);
   assign sp_m2 = sp_ff - SP_W'(2);

   smx_ram #(
      .WIDTH (smx_pkg::WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_data_ram (
      .clock (clock),
      .we    (commit && upd.dm_we),
      .waddr (b_item_ff.opnd[MI_W-1:0]),
      .wdata (upd.dm_wdata),
      .re    (req_accept),
      .raddr (req_operand[MI_W-1:0]),
      .rdata (dm_rdata)
   );

   // On a push the old top spills to entry sp-1.
   smx_ram #(
      .WIDTH (smx_pkg::WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (commit && upd.st_we),
      .waddr (sp_m1[SI_W-1:0]),
      .wdata (top_ff),
      .re    (req_accept),
      .raddr (sp_m2[SI_W-1:0]),
      .rdata (st_rdata)
   );

   smx_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .MEM_WORDS   (MEM_WORDS)
   ) u_exec (
      .item     (b_item_ff),
      .sp       (sp_ff),
      .ip       (ip_ff),
      .halt     (halt_ff),
      .top      (top_ff),
      .plen     (plen_ff),
      .dm_rdata (dm_rdata),
      .st_rdata (st_rdata),
      .upd      (upd),
      .sp_nx    (sp_nx)
   );

   // State commits together with the rsp register load.
   assign sp_in   = commit ? sp_nx   : sp_ff;
   assign ip_in   = commit ? upd.ip  : ip_ff;
   assign halt_in = commit ? upd.halt : halt_ff;
   assign top_in  = commit ? upd.top : top_ff;

   assign out_ip_in    = commit ? upd.ip : out_ip_ff;
   assign out_halt_in  = commit ? upd.halt : out_halt_ff;
   assign out_rdata_in = commit ? upd.read_data : out_rdata_ff;
   // empty stack reports zero; the cached top is stale then
   assign out_top_in   = commit ? ((sp_nx != '0) ? upd.top : '0) : out_top_ff;
   assign out_count_in = commit ? smx_pkg::COUNT_W'(sp_nx) : out_count_ff;
   assign out_fault_in = commit ? upd.fault : out_fault_ff;

   // Configuration: one register, program_length.
   assign csr_wr  = psel && penable && pwrite && pready;
   assign plen_in = csr_wr ? pwdata[smx_pkg::IP_W-1:0] : plen_ff;
   assign pready  = 1'b1;
   assign prdata  = (paddr == smx_pkg::CSR_PLEN_ADDR) ?
                    {{(smx_pkg::CSR_DW - smx_pkg::IP_W){1'b0}}, plen_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
         ip_ff        <= '0;
         halt_ff      <= 1'b0;
         plen_ff      <= smx_pkg::PLEN_RESET;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
         ip_ff        <= ip_in;
         halt_ff      <= halt_in;
         plen_ff      <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff    <= b_item_in;
      top_ff       <= top_in;
      out_ip_ff    <= out_ip_in;
      out_halt_ff  <= out_halt_in;
      out_rdata_ff <= out_rdata_in;
      out_top_ff   <= out_top_in;
      out_count_ff <= out_count_in;
      out_fault_ff <= out_fault_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_ip     = out_ip_ff;
   assign rsp_halted      = out_halt_ff;
   assign rsp_read_data   = out_rdata_ff;
   assign rsp_top_value   = out_top_ff;
   assign rsp_stack_count = out_count_ff;
   assign rsp_fault       = out_fault_ff;

   // ---------------------------------------------------------------- checks
   // interlock: never two accepts in consecutive cycles
   a_accept_spacing: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_accept)
      else $error("item accepted while previous item still executing");

   // a waiting result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !commit)
      else $error("commit into a stalled rsp register");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   // instructions executed while halted leave the machine untouched
   a_halt_freeze: assert property (@(posedge clock) disable iff (reset)
      (commit && halt_ff && (b_item_ff.op == smx_pkg::OP_EXEC))
      |=> ($stable(sp_ff) && $stable(ip_ff) && halt_ff))
      else $error("halted machine changed state");

endmodule
